// ===== sv/hnps_pkg.sv =====
// Package for the held-note priority stack.
// Holds field widths, list depth and action codes; no dependencies.
`default_nettype none

package hnps_pkg;

	// Field widths of one transaction.
	localparam int NOTE_W  = 7;
	localparam int COUNT_W = 8;

	// Full depth of the held-note list; distinct MIDI notes cannot exceed it.
	localparam int LIST_DEPTH = 128;

	// Key event codes carried on the action field.
	localparam logic ACT_NOTE_ON  = 1'b0;
	localparam logic ACT_NOTE_OFF = 1'b1;

endpackage : hnps_pkg

`default_nettype wire

// ===== sv/held_note_priority_stack.sv =====
// Top level of the held-note priority stack (last-note priority note list).
// Depends on hnps_pkg for widths, depth and action codes.
//
// Usage: a key event transaction (action, note) is taken when start is high
// and busy is low. A note-on moves the note to the newest place of the list
// (appending it if absent, dropping the oldest entry when the list is full);
// a note-off removes the note if it is held. Every transaction produces one
// result (held_count, any_held, newest_note), shown for exactly one cycle
// with done high. The receiver cannot stall; the result must be taken then.
//
// The list lives in one synchronous RAM (one write and one read port, read
// data registered). A transaction scans the held entries once to find the
// note, then walks the newer entries down one place to close the gap, then
// appends or reads back the newest entry. Each pass moves one entry per
// cycle through the RAM read port. busy is high from acceptance to done;
// one transaction at a time. Reset empties the list by clearing the count;
// the RAM itself is not cleared.
`default_nettype none

module held_note_priority_stack
	import hnps_pkg::*;
#(
	parameter int MAX_NOTES = LIST_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               action,
	input  wire logic [NOTE_W-1:0]  note,
	output logic                    done,
	output logic [COUNT_W-1:0]      held_count,
	output logic                    any_held,
	output logic [NOTE_W-1:0]       newest_note
);

	localparam int AW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
	localparam logic [COUNT_W-1:0] CAP = COUNT_W'(MAX_NOTES);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_DECIDE,
		S_SHIFT,
		S_APPEND,
		S_READ_NEW
	} state_t;

	state_t              state_q;
	logic [COUNT_W-1:0]  cnt_q;
	logic [COUNT_W-1:0]  idx_q;
	logic                act_q;
	logic [NOTE_W-1:0]   note_q;
	logic                found_q;
	logic [AW-1:0]       pos_q;
	logic                rvalid_s1;
	logic [AW-1:0]       raddr_s1;
	logic [NOTE_W-1:0]   rdata_s1;

	// RAM access requests.
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [NOTE_W-1:0]   wr_data;

	logic [NOTE_W-1:0]   note_mem [MAX_NOTES];

	logic                scan_more;
	logic                scan_end;
	logic                hit;

	assign scan_more = (idx_q != cnt_q);
	assign scan_end  = !scan_more && !rvalid_s1;
	assign hit       = rvalid_s1 && (rdata_s1 == note_q);
	assign busy      = (state_q != S_IDLE);

	// Read and write port control. A shift pass writes entry k-1 while it
	// reads entry k+1, so the two ports never touch the same entry.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = raddr_s1 - AW'(1);
		wr_data = rdata_s1;
		case (state_q)
			S_SEARCH: begin
				rd_en = scan_more;
			end
			S_SHIFT: begin
				rd_en = scan_more;
				wr_en = rvalid_s1;
			end
			S_APPEND: begin
				if (act_q == ACT_NOTE_ON) begin
					wr_en   = 1'b1;
					wr_addr = cnt_q[AW-1:0];
					wr_data = note_q;
				end else if (cnt_q != '0) begin
					rd_en   = 1'b1;
					rd_addr = AW'(cnt_q - COUNT_W'(1));
				end
			end
			default: begin
			end
		endcase
	end

	// Note list memory with registered read data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			note_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= note_mem[rd_addr];
		end
	end

	// Sequencer: search, close the gap, then append or read the newest entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			act_q       <= ACT_NOTE_ON;
			note_q      <= '0;
			found_q     <= 1'b0;
			pos_q       <= '0;
			rvalid_s1   <= 1'b0;
			raddr_s1    <= '0;
			done        <= 1'b0;
			held_count  <= '0;
			any_held    <= 1'b0;
			newest_note <= '0;
		end else begin
			rvalid_s1 <= rd_en;
			raddr_s1  <= rd_addr;
			done      <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						act_q   <= action;
						note_q  <= note;
						found_q <= 1'b0;
						idx_q   <= '0;
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (scan_more) begin
						idx_q <= idx_q + COUNT_W'(1);
					end
					if (hit) begin
						found_q <= 1'b1;
						pos_q   <= raddr_s1;
					end
					if (scan_end) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					// Remove the matching entry, or the oldest one when a new
					// note arrives at a full list.
					if (found_q) begin
						idx_q   <= COUNT_W'(pos_q) + COUNT_W'(1);
						state_q <= S_SHIFT;
					end else if (act_q == ACT_NOTE_ON && cnt_q == CAP) begin
						idx_q   <= COUNT_W'(1);
						state_q <= S_SHIFT;
					end else begin
						state_q <= S_APPEND;
					end
				end
				S_SHIFT: begin
					if (scan_more) begin
						idx_q <= idx_q + COUNT_W'(1);
					end
					if (scan_end) begin
						cnt_q   <= cnt_q - COUNT_W'(1);
						state_q <= S_APPEND;
					end
				end
				S_APPEND: begin
					if (act_q == ACT_NOTE_ON) begin
						cnt_q       <= cnt_q + COUNT_W'(1);
						done        <= 1'b1;
						held_count  <= cnt_q + COUNT_W'(1);
						any_held    <= 1'b1;
						newest_note <= note_q;
						state_q     <= S_IDLE;
					end else if (cnt_q == '0) begin
						done        <= 1'b1;
						held_count  <= '0;
						any_held    <= 1'b0;
						newest_note <= '0;
						state_q     <= S_IDLE;
					end else begin
						state_q <= S_READ_NEW;
					end
				end
				S_READ_NEW: begin
					done        <= 1'b1;
					held_count  <= cnt_q;
					any_held    <= 1'b1;
					newest_note <= rdata_s1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The list never grows beyond its capacity.
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CAP)
		else $error("held note count exceeds capacity");

	// A result only follows a transaction in progress.
	assert property (@(posedge clk) disable iff (!arst_n) done |-> $past(busy))
		else $error("result strobe without a transaction in progress");

	// Any-held flag agrees with the reported count.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (any_held == (held_count != '0)))
		else $error("any_held disagrees with held_count");

	// An accepted transaction makes the block busy on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("accepted transaction did not start");

endmodule : held_note_priority_stack

`default_nettype wire

// ===== verif/held_note_priority_stack_tb.sv =====
// Self-checking testbench for the held-note priority stack.
// Depends on hnps_pkg and held_note_priority_stack; key events are checked against a local list model.
`timescale 1ns / 1ps

module held_note_priority_stack_tb;
	import hnps_pkg::*;

	// Capacity given to the block; the model clamps it to 1..LIST_DEPTH, which the block itself does not do.
	localparam int STACK_CAP  = LIST_DEPTH;
	localparam int EFF_CAP    = (STACK_CAP > LIST_DEPTH) ? LIST_DEPTH :
		((STACK_CAP < 1) ? 1 : STACK_CAP);
	localparam int TARGET_ITEMS = 1300;
	localparam int IDLE_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 300;
	localparam int MAX_REPORTS  = 10;

	// One pending key event: the fields, the idle cycles before it and a drain request.
	typedef struct {
		logic              act;
		logic [NOTE_W-1:0] key;
		int                gap;
		bit                drain_first;
	} key_event_t;

	// One expected status transaction.
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               any;
		logic [NOTE_W-1:0]  newest;
	} held_status_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               action = ACT_NOTE_ON;
	logic [NOTE_W-1:0]  note = '0;
	logic               busy;
	logic               done;
	logic [COUNT_W-1:0] held_count;
	logic               any_held;
	logic [NOTE_W-1:0]  newest_note;

	key_event_t   key_q[$];
	held_status_t status_q[$];
	int           fail_count = 0;
	int           idle_cycles = 0;
	int           wait_cycles = 0;

	// Model of the held list, oldest note at index 0.
	logic [NOTE_W-1:0] held_list[LIST_DEPTH];
	int                held_num = 0;

	// Notes marked held while the stimulus is built, used to aim releases at held notes.
	bit [LIST_DEPTH-1:0] gen_held = '0;
	int                  gen_num = 0;
	int                  queued_items = 0;

	held_note_priority_stack #(
		.MAX_NOTES(STACK_CAP)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.note(note),
		.done(done),
		.held_count(held_count),
		.any_held(any_held),
		.newest_note(newest_note)
	);

	// Clock with an 8 ns period.
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Record a failure; only the first few are printed in full.
	function automatic void flag_mismatch(string what, int exp_v, int act_v);
		fail_count++;
		if (fail_count <= MAX_REPORTS) begin
			$display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, exp_v, act_v);
		end
	endfunction

	// Remove the list entry at pos and close the gap.
	function automatic void drop_entry(int pos);
		int i;
		for (i = pos; i + 1 < held_num; i++) begin
			held_list[i] = held_list[i + 1];
		end
		held_num--;
	endfunction

	// Apply one accepted key event to the list model and queue the status it yields.
	function automatic void apply_key_event(logic act, logic [NOTE_W-1:0] key);
		int           pos;
		int           i;
		held_status_t st;
		pos = held_num;
		for (i = 0; i < held_num && pos == held_num; i++) begin
			if (held_list[i] == key) begin
				pos = i;
			end
		end
		if (pos < held_num) begin
			drop_entry(pos);
		end
		if (act == ACT_NOTE_ON) begin
			if (held_num >= EFF_CAP) begin
				drop_entry(0);
			end
			held_list[held_num] = key;
			held_num++;
		end
		st.count  = COUNT_W'(held_num);
		st.any    = (held_num != 0);
		st.newest = (held_num != 0) ? held_list[held_num - 1] : '0;
		status_q.insert(status_q.size(), st);
	endfunction

	// Idle cycles ahead of an event: mostly none or a few, sometimes long.
	function automatic int next_gap(bit quiet);
		int r;
		if (quiet) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 45) begin
			return 0;
		end else if (r < 80) begin
			return $urandom_range(1, 4);
		end else if (r < 95) begin
			return $urandom_range(5, 40);
		end
		return $urandom_range(41, 300);
	endfunction

	// Pick a random note that is held (want_held) or not held; the caller ensures one exists.
	function automatic logic [NOTE_W-1:0] pick_note(bit want_held);
		int k;
		int i;
		logic [NOTE_W-1:0] found;
		k = want_held ? $urandom_range(0, gen_num - 1) : $urandom_range(0, LIST_DEPTH - gen_num - 1);
		found = '0;
		for (i = 0; i < LIST_DEPTH; i++) begin
			if (gen_held[i] == want_held) begin
				if (k == 0) begin
					found = NOTE_W'(i);
				end
				k--;
			end
		end
		return found;
	endfunction

	// Append a key event to the pending queue and track which notes it leaves held.
	function automatic void queue_key(logic act, logic [NOTE_W-1:0] key, int gap, bit drain_first);
		key_event_t ev;
		ev.act         = act;
		ev.key         = key;
		ev.gap         = gap;
		ev.drain_first = drain_first;
		key_q.insert(key_q.size(), ev);
		gen_held[key] = (act == ACT_NOTE_ON);
		gen_num = $countones(gen_held);
		queued_items++;
	endfunction

	// Driver: take the accepted transaction into the model, then present the next event.
	always @(posedge clk or negedge arst_n) begin : drv_blk
		key_event_t ev;
		bit         holding;
		if (!arst_n) begin
			start       <= 1'b0;
			action      <= ACT_NOTE_ON;
			note        <= '0;
			wait_cycles = 0;
		end else begin
			holding = start;
			if (start && !busy) begin
				apply_key_event(action, note);
				holding = 1'b0;
			end
			if (!holding) begin
				if (key_q.size() == 0) begin
					start <= 1'b0;
				end else if (wait_cycles < key_q[0].gap) begin
					wait_cycles++;
					start <= 1'b0;
				end else if (key_q[0].drain_first && (status_q.size() != 0 || busy)) begin
					start <= 1'b0;
				end else begin
					ev = key_q.pop_front();
					wait_cycles = 0;
					start  <= 1'b1;
					action <= ev.act;
					note   <= ev.key;
				end
			end
		end
	end

	// Monitor: compare every status transaction with the oldest expectation.
	always @(posedge clk) begin : mon_blk
		held_status_t exp_st;
		if (arst_n && done) begin
			if (status_q.size() == 0) begin
				flag_mismatch("unexpected status transaction, count", -1, int'(held_count));
			end else begin
				exp_st = status_q.pop_front();
				if (held_count !== exp_st.count) begin
					flag_mismatch("held_count", int'(exp_st.count), int'(held_count));
				end
				if (any_held !== exp_st.any) begin
					flag_mismatch("any_held", int'(exp_st.any), int'(any_held));
				end
				if (newest_note !== exp_st.newest) begin
					flag_mismatch("newest_note", int'(exp_st.newest), int'(newest_note));
				end
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin : stim_blk
		int  order[LIST_DEPTH];
		int  i;
		int  j;
		int  tmp;
		int  burst_len;
		int  mode;
		int  r;
		bit  quiet;

		// Directed: empty list, extremes of the note, repeated press, releases
		// of held and of absent notes, and alternating bit patterns.
		queue_key(ACT_NOTE_OFF, 7'd60, 0, 1'b0);
		queue_key(ACT_NOTE_OFF, 7'd127, 2, 1'b0);
		queue_key(ACT_NOTE_ON, 7'd0, 0, 1'b0);
		queue_key(ACT_NOTE_ON, 7'd127, 0, 1'b0);
		queue_key(ACT_NOTE_ON, 7'd0, 1, 1'b0);
		queue_key(ACT_NOTE_OFF, 7'd127, 0, 1'b0);
		queue_key(ACT_NOTE_OFF, 7'd0, 0, 1'b1);
		queue_key(ACT_NOTE_OFF, 7'd0, 0, 1'b0);
		queue_key(ACT_NOTE_ON, 7'd85, 30, 1'b0);
		queue_key(ACT_NOTE_ON, 7'd42, 0, 1'b0);
		queue_key(ACT_NOTE_ON, 7'd85, 0, 1'b0);
		queue_key(ACT_NOTE_OFF, 7'd99, 0, 1'b0);
		queue_key(ACT_NOTE_OFF, 7'd85, 0, 1'b0);
		queue_key(ACT_NOTE_ON, 7'd42, 0, 1'b0);
		queue_key(ACT_NOTE_OFF, 7'd42, 0, 1'b1);

		// Fill the whole list in a random order, then press held notes while full.
		for (i = 0; i < LIST_DEPTH; i++) begin
			order[i] = i;
		end
		for (i = LIST_DEPTH - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		quiet = 1'b1;
		for (i = 0; i < LIST_DEPTH; i++) begin
			if (i == 64) begin
				quiet = 1'b0;
			end
			queue_key(ACT_NOTE_ON, NOTE_W'(order[i]), next_gap(quiet), 1'b0);
		end
		for (i = 0; i < 4; i++) begin
			queue_key(ACT_NOTE_ON, pick_note(1'b1), next_gap(1'b0), 1'b0);
		end

		// Random bursts that fill, drain or mix, with an occasional full drain.
		while (queued_items < TARGET_ITEMS) begin
			mode      = $urandom_range(0, 2);
			burst_len = $urandom_range(10, 120);
			quiet     = ($urandom_range(0, 3) == 0);
			for (i = 0; i < burst_len && queued_items < TARGET_ITEMS; i++) begin
				r = $urandom_range(0, 99);
				if (mode == 0) begin
					r = (r < 80) ? 0 : ((r < 90) ? 1 : 2);
				end else if (mode == 1) begin
					r = (r < 75) ? 3 : ((r < 85) ? 2 : 0);
				end else begin
					r = (r < 40) ? 0 : ((r < 80) ? 3 : ((r < 90) ? 1 : 2));
				end
				// 0: press a new note, 1: press a held note again,
				// 2: release any note, 3: release a held note.
				if (r == 0 && gen_num == LIST_DEPTH) begin
					r = 1;
				end
				if ((r == 1 || r == 3) && gen_num == 0) begin
					r = (r == 1) ? 0 : 2;
				end
				case (r)
					0: begin
						queue_key(ACT_NOTE_ON, pick_note(1'b0), next_gap(quiet),
							$urandom_range(0, 49) == 0);
					end
					1: begin
						queue_key(ACT_NOTE_ON, pick_note(1'b1), next_gap(quiet), 1'b0);
					end
					2: begin
						queue_key(ACT_NOTE_OFF, NOTE_W'($urandom_range(0, 127)), next_gap(quiet),
							1'b0);
					end
					default: begin
						queue_key(ACT_NOTE_OFF, pick_note(1'b1), next_gap(quiet),
							$urandom_range(0, 49) == 0);
					end
				endcase
			end
		end

		// Hold reset, then release it away from the active edge.
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for every event to be taken and every status to arrive, then settle.
		while (key_q.size() != 0 || start || status_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule : held_note_priority_stack_tb

// ===== filelist.f =====
sv/hnps_pkg.sv
sv/held_note_priority_stack.sv
verif/held_note_priority_stack_tb.sv
